// ===== design/cbd_pkg.sv =====
// Shared types and constants for the cursor block deinterleaver.
`timescale 1ns / 1ps

package cbd_pkg;

    // Field widths
    localparam int SYM_W = 8;
    localparam int COL_W = 9;
    localparam int OP_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REWIND       = 2'd1;

    // Register reset values
    localparam logic [COL_W-1:0] RST_COLUMN_COUNT = 9'd54;
    localparam logic [COL_W-1:0] RST_REWIND       = 9'd17;
    localparam logic [COL_W-1:0] RST_SHIFT_MOD    =
        COL_W'(int'(RST_REWIND) % int'(RST_COLUMN_COUNT));

    // Status of the serial modulo unit
    typedef struct packed {
        logic             busy;
        logic [COL_W-1:0] shift;
    } cbd_mod_status_t;

endpackage

// ===== design/cbd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module cbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cbd_mod_unit.sv =====
// Bit-serial remainder unit: rewind step modulo the effective column count.
`timescale 1ns / 1ps

module cbd_mod_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [cbd_pkg::COL_W-1:0] dividend,
    input  logic [cbd_pkg::COL_W-1:0] divisor,
    output cbd_pkg::cbd_mod_status_t  status
);
    import cbd_pkg::*;

    localparam int CNT_W = $clog2(COL_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [COL_W-1:0] rem_reg;
    logic [COL_W-1:0] result_reg;

    logic [COL_W:0]   trial;
    logic [COL_W:0]   rem_step;
    logic [COL_W-1:0] rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, dividend[cnt_reg]};
        rem_step = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;
        rem_next = rem_step[COL_W-1:0];
    end

    // Sequencer, MSB first; a new start restarts the pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            result_reg <= RST_SHIFT_MOD;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(COL_W - 1);
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            if (cnt_reg == '0) begin
                busy_reg   <= 1'b0;
                result_reg <= rem_next;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign status.busy  = busy_reg;
    assign status.shift = result_reg;

endmodule

// ===== design/cursor_block_deinterleaver.sv =====
// Top level: cursor control, configuration and symbol store of the deinterleaver.
//
// The block keeps ROWS rows by column_count columns of 8-bit symbols in one
// RAM and walks a row/column cursor over it: writes advance one row and step
// the column back by the rewind step, reads advance READ_ROW_STEP rows, restart
// returns the cursor to row 0, column 0. Every write or read is one RAM access
// plus a cursor update; unless stalled as below, one item is taken per cycle.
// A read result appears in the cycle after acceptance, from the RAM's registered
// read port; while it waits on m_tready, no new item is taken. A write to either
// register also restarts the cursor and starts a bit-serial remainder of the
// rewind step by the column count, which holds s_tready low while it runs.
// Store contents are not cleared at reset; unwritten entries read any value.
// Addresses at or beyond STORE_DEPTH drop writes and read as zero.
`timescale 1ns / 1ps

module cursor_block_deinterleaver #(
    parameter int ROWS          = 40,
    parameter int READ_ROW_STEP = 9,
    parameter int STORE_DEPTH   = 16384
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] symbol_in
    input  logic [cbd_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] symbol_out
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbd_pkg::COL_W-1:0]     cfg_wdata
);
    import cbd_pkg::*;

    localparam int ROW_W    = $clog2(ROWS);
    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int ADDR_W   = (ROW_W + COL_W + 1 > AW) ? (ROW_W + COL_W + 1) : AW;
    localparam int STEP_MOD = READ_ROW_STEP % ROWS;

    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] rewind_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             rd_valid_reg;
    logic             oob_reg;

    cbd_mod_status_t  mod_status;
    logic             cfg_hit;
    logic             accept;
    logic             acc_write, acc_read, acc_restart;

    logic [COL_W-1:0] cc;
    logic [ADDR_W-1:0] addr;
    logic             in_range;

    logic [ROW_W:0]   row_inc;
    logic [ROW_W:0]   row_sum;
    logic [ROW_W:0]   row_rd;
    logic [COL_W:0]   col_inc;
    logic [COL_W-1:0] col_wrap;
    logic [COL_W-1:0] col_wr_base;
    logic [COL_W:0]   col_back;
    logic [SYM_W-1:0] ram_rdata;

    // Handshake decode
    assign cfg_hit     = cfg_we && (cfg_index == REG_COLUMN_COUNT ||
                                    cfg_index == REG_REWIND);
    assign s_tready    = !mod_status.busy && (!rd_valid_reg || m_tready);
    assign accept      = s_tvalid && s_tready;
    assign acc_write   = accept && (s_tuser == OP_WRITE);
    assign acc_read    = accept && (s_tuser == OP_READ);
    assign acc_restart = accept && (s_tuser == OP_RESTART);

    // Effective column count and store address
    assign cc   = (column_count_reg == '0) ? COL_W'(1) : column_count_reg;
    assign addr = ADDR_W'(row_reg) * ADDR_W'(column_count_reg) + ADDR_W'(col_reg);
    assign in_range = 32'(addr) < 32'(STORE_DEPTH);

    // Next cursor
    always_comb begin
        row_inc  = {1'b0, row_reg} + 1'b1;
        row_sum  = {1'b0, row_reg} + (ROW_W + 1)'(STEP_MOD);
        row_rd   = (row_sum >= (ROW_W + 1)'(ROWS)) ? (row_sum - (ROW_W + 1)'(ROWS)) : row_sum;
        col_inc  = {1'b0, col_reg} + 1'b1;
        col_wrap = (col_inc >= {1'b0, cc}) ? '0 : col_inc[COL_W-1:0];
        // The column always stays below the count: config writes restart it
        col_wr_base = (row_inc >= (ROW_W + 1)'(ROWS)) ? col_wrap : col_reg;
        col_back = (col_wr_base >= mod_status.shift)
                 ? ({1'b0, col_wr_base} - {1'b0, mod_status.shift})
                 : ({1'b0, col_wr_base} + {1'b0, cc} - {1'b0, mod_status.shift});

        row_next = row_reg;
        col_next = col_reg;
        priority if (acc_write) begin
            row_next = (row_inc >= (ROW_W + 1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
            col_next = col_back[COL_W-1:0];
        end else if (acc_read) begin
            row_next = row_rd[ROW_W-1:0];
            col_next = (row_rd == '0) ? col_wrap : col_reg;
        end else if (acc_restart) begin
            row_next = '0;
            col_next = '0;
        end
    end

    // Registers, cursor and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= RST_COLUMN_COUNT;
            rewind_reg       <= RST_REWIND;
            row_reg          <= '0;
            col_reg          <= '0;
            rd_valid_reg     <= 1'b0;
        end else begin
            if (cfg_hit) begin
                if (cfg_index == REG_COLUMN_COUNT) begin
                    column_count_reg <= cfg_wdata;
                end else begin
                    rewind_reg <= cfg_wdata;
                end
                row_reg <= '0;
                col_reg <= '0;
            end else begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (acc_read) begin
                rd_valid_reg <= 1'b1;
            end else if (m_tready) begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    // Out-of-range flag follows the read data
    always_ff @(posedge aclk) begin
        if (acc_read) begin
            oob_reg <= !in_range;
        end
    end

    // Rewind step reduced by the column count after each register write
    cbd_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cfg_hit),
        .dividend (rewind_reg),
        .divisor  (cc),
        .status   (mod_status)
    );

    // Symbol store; a write is visible to a read in the next cycle
    cbd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (acc_write && in_range),
        .waddr (addr[AW-1:0]),
        .wdata (s_tdata),
        .re    (acc_read),
        .raddr (addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_tvalid = rd_valid_reg;
    assign m_tdata  = oob_reg ? '0 : ram_rdata;

    // Checks
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_status.busy |-> !s_tready)
        else $error("item accepted while shift remainder is busy");

    a_cfg_starts_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> mod_status.busy && row_reg == '0 && col_reg == '0)
        else $error("register write did not restart cursor and remainder");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_read |=> m_tvalid)
        else $error("accepted read produced no result");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < cc)
        else $error("column cursor beyond column count");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_reg) < 32'(ROWS))
        else $error("row cursor beyond row count");

endmodule
